@@ rtl/core/btmx_pkg.sv @@
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and codes for the binary trie max-xor block
// operation and status codes, walk state type and fixed field widths
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int DATA_W      = 32;
  localparam int KEY_COUNT_W = 13;
  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LEAF,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/binary_trie_max_xor.sv @@
// ----------------------------------------------------------------------------
// binary_trie_max_xor: bitwise binary trie with maximum-xor query
// clear, insert and query operations on a trie of KEY_BITS-bit keys whose
// child links live in a single-port-read, single-port-write node memory
// ----------------------------------------------------------------------------
// Pulse start with an operation while busy is low; busy stays high until the
// one result of that item has been shown on status, best_key and best_xor for
// the single cycle in which done is high, and the result must be taken then.
// A clear, an unused code, a rejected insert and a query on an empty trie go
// from accept straight to the result; a query walks the trie levels, an insert
// walks them and its leaf. The walk advances one trie level per clock:
// each level's node memory read returns in the next cycle and picks the next
// node address. The root's links are held in registers, so no memory clearing
// pass is needed after reset or clear.
module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int KEY_BITS      = 32,
  parameter int NODE_CAPACITY = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  logic [DATA_W-1:0] key_value,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] best_key,
  output logic [DATA_W-1:0] best_xor
);

  localparam int IDX_W      = $clog2(NODE_CAPACITY);
  localparam int CNT_W      = $clog2(NODE_CAPACITY + 1);
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int FULL_LIMIT = NODE_CAPACITY - KEY_BITS;

  // node memory: upper half is the one-link, lower half the zero-link
  logic [2*IDX_W-1:0] links_mem [NODE_CAPACITY];
  logic [2*IDX_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [2*IDX_W-1:0] mem_wdata;

  state_t state, state_next;

  op_t                  op;
  logic [KEY_BITS-1:0]  key;
  logic [KEY_BITS-1:0]  best;
  logic [LVL_W-1:0]     lvl;
  logic [IDX_W-1:0]     node;
  logic                 fresh;
  status_t              res_status;
  logic [IDX_W-1:0]     root_link0, root_link1;
  logic [CNT_W-1:0]     node_count;
  logic [KEY_COUNT_W-1:0] key_count;

  logic [IDX_W-1:0] links0, links1, l_opp, l_same, q_next, i_next, new_idx;
  logic             key_bit, q_dir, q_stop, i_miss, trie_full;
  op_t              op_in;
  logic [63:0]      best_ext, xor_ext;

  assign op_in     = op_t'(operation);
  assign trie_full = node_count > CNT_W'(FULL_LIMIT);
  assign new_idx   = node_count[IDX_W-1:0];

  // links of the node at the current level
  always_comb begin
    if (node == '0) begin
      links0 = root_link0;
      links1 = root_link1;
    end else if (fresh) begin
      links0 = '0;
      links1 = '0;
    end else begin
      links0 = rd_data[IDX_W-1:0];
      links1 = rd_data[2*IDX_W-1:IDX_W];
    end
    key_bit = key[lvl];
    l_same  = key_bit ? links1 : links0;
    l_opp   = key_bit ? links0 : links1;
    // query prefers the child opposite to the key bit
    if (l_opp != '0) begin
      q_dir  = ~key_bit;
      q_next = l_opp;
    end else begin
      q_dir  = key_bit;
      q_next = l_same;
    end
    q_stop = (q_next == '0);
    i_miss = (l_same == '0);
    i_next = i_miss ? new_idx : l_same;
  end

  // memory port control
  always_comb begin
    rd_addr   = (op == OP_INSERT) ? i_next : q_next;
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = '0;
    if (state == S_WALK && op == OP_INSERT && i_miss && node != '0) begin
      mem_we    = 1'b1;
      mem_wdata = key_bit ? {new_idx, links0} : {links1, new_idx};
    end else if (state == S_LEAF && fresh) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      links_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= links_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    done       = (state == S_DONE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority if (op_in == OP_INSERT && !trie_full) begin
            state_next = S_WALK;
          end else if (op_in == OP_QUERY && key_count != '0) begin
            state_next = S_WALK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (op == OP_INSERT) begin
          if (lvl == '0) begin
            state_next = S_LEAF;
          end
        end else if (q_stop || lvl == '0) begin
          state_next = S_DONE;
        end
      end
      S_LEAF: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // trie control state
  always_ff @(posedge clk) begin
    if (rst) begin
      root_link0 <= '0;
      root_link1 <= '0;
      node_count <= CNT_W'(1);
      key_count  <= '0;
    end else begin
      if (state == S_IDLE && start && op_in == OP_CLEAR) begin
        root_link0 <= '0;
        root_link1 <= '0;
        node_count <= CNT_W'(1);
        key_count  <= '0;
      end
      if (state == S_WALK && op == OP_INSERT && i_miss) begin
        node_count <= node_count + 1'b1;
        if (node == '0) begin
          if (key_bit) begin
            root_link1 <= new_idx;
          end else begin
            root_link0 <= new_idx;
          end
        end
      end
      if (state == S_LEAF && key_count != KEY_COUNT_MAX) begin
        key_count <= key_count + 1'b1;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op    <= op_in;
      key   <= KEY_BITS'({32'b0, key_value});
      best  <= '0;
      node  <= '0;
      fresh <= 1'b0;
      lvl   <= LVL_W'(KEY_BITS - 1);
      priority if (op_in == OP_INSERT && trie_full) begin
        res_status <= ST_FULL;
      end else if (op_in == OP_QUERY && key_count == '0) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
    end else if (state == S_WALK) begin
      if (lvl != '0) begin
        lvl <= lvl - 1'b1;
      end
      if (op == OP_INSERT) begin
        node  <= i_next;
        fresh <= i_miss;
      end else if (!q_stop) begin
        best[lvl] <= q_dir;
        node      <= q_next;
      end
    end
  end

  assign best_ext = 64'(best);
  assign xor_ext  = (op == OP_QUERY && res_status == ST_OK) ? 64'(best ^ key) : 64'd0;
  assign status   = res_status;
  assign best_key = best_ext[DATA_W-1:0];
  assign best_xor = xor_ext[DATA_W-1:0];

  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(NODE_CAPACITY)) else $error("node store overrun");

  a_walk_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (CNT_W'(node) < node_count))
    else $error("walk reached an unallocated node");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (best_key == '0 && best_xor == '0))
    else $error("rejected item returned nonzero fields");

endmodule
